@@ rtl/lcmr_pkg.sv @@
`default_nettype none
package lcmr_pkg;

   // result range: magnitudes fold into 31 unsigned bits
   localparam int RESULT_WIDTH = 31;
   localparam logic [RESULT_WIDTH-1:0] RESULT_MAX = {RESULT_WIDTH{1'b1}};

   // iteration counters of the serial units
   localparam int COUNT_WIDTH = $clog2(RESULT_WIDTH);
   localparam logic [COUNT_WIDTH-1:0] LAST_COUNT = COUNT_WIDTH'(RESULT_WIDTH - 1);

   // status of one serial unit toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage
`default_nettype wire

@@ rtl/lcmr_gcd.sv @@
`default_nettype none
module lcmr_gcd (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire  [lcmr_pkg::RESULT_WIDTH-1:0]     op_a,
   input  wire  [lcmr_pkg::RESULT_WIDTH-1:0]     op_b,
   output lcmr_pkg::unit_stat_type               stat,
   output logic [lcmr_pkg::RESULT_WIDTH-1:0]     gcd_out
);

   typedef enum logic [1:0] {G_IDLE, G_REDUCE, G_RESTORE} gcd_state_type;

   gcd_state_type                          state_ff;
   logic                                   done_ff;
   logic [lcmr_pkg::RESULT_WIDTH-1:0]      a_ff;
   logic [lcmr_pkg::RESULT_WIDTH-1:0]      b_ff;
   logic [lcmr_pkg::COUNT_WIDTH-1:0]       k_ff;
   logic [lcmr_pkg::RESULT_WIDTH-1:0]      diff_ab;
   logic [lcmr_pkg::RESULT_WIDTH-1:0]      diff_ba;

   assign diff_ab = a_ff - b_ff;
   assign diff_ba = b_ff - a_ff;

   // binary gcd: common factors of two counted in k, restored by shifting back
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == G_RESTORE) && (k_ff == '0);
         case (state_ff)
            G_IDLE: begin
               if (start) begin
                  a_ff     <= op_a;
                  b_ff     <= op_b;
                  k_ff     <= '0;
                  state_ff <= G_REDUCE;
               end
            end
            G_REDUCE: begin
               if (a_ff == b_ff) begin
                  state_ff <= G_RESTORE;
               end else if (!a_ff[0] && !b_ff[0]) begin
                  a_ff <= {1'b0, a_ff[lcmr_pkg::RESULT_WIDTH-1:1]};
                  b_ff <= {1'b0, b_ff[lcmr_pkg::RESULT_WIDTH-1:1]};
                  k_ff <= k_ff + 1'b1;
               end else if (!a_ff[0]) begin
                  a_ff <= {1'b0, a_ff[lcmr_pkg::RESULT_WIDTH-1:1]};
               end else if (!b_ff[0]) begin
                  b_ff <= {1'b0, b_ff[lcmr_pkg::RESULT_WIDTH-1:1]};
               end else if (a_ff > b_ff) begin
                  a_ff <= {1'b0, diff_ab[lcmr_pkg::RESULT_WIDTH-1:1]};
               end else begin
                  b_ff <= {1'b0, diff_ba[lcmr_pkg::RESULT_WIDTH-1:1]};
               end
            end
            G_RESTORE: begin
               if (k_ff == '0) begin
                  state_ff <= G_IDLE;
               end else begin
                  a_ff <= {a_ff[lcmr_pkg::RESULT_WIDTH-2:0], 1'b0};
                  k_ff <= k_ff - 1'b1;
               end
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

   assign stat.busy = (state_ff != G_IDLE);
   assign stat.done = done_ff;
   assign gcd_out   = a_ff;

endmodule
`default_nettype wire

@@ rtl/lcmr_div.sv @@
`default_nettype none
module lcmr_div (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire  [lcmr_pkg::RESULT_WIDTH-1:0]     dividend,
   input  wire  [lcmr_pkg::RESULT_WIDTH-1:0]     divisor,
   output lcmr_pkg::unit_stat_type               stat,
   output logic [lcmr_pkg::RESULT_WIDTH-1:0]     quotient
);

   localparam int RW = lcmr_pkg::RESULT_WIDTH;

   typedef enum logic {D_IDLE, D_RUN} div_state_type;

   div_state_type                     state_ff;
   logic                              done_ff;
   logic [RW:0]                       rem_ff;
   logic [RW-1:0]                     quo_ff;
   logic [RW-1:0]                     dsr_ff;
   logic [lcmr_pkg::COUNT_WIDTH-1:0]  cnt_ff;
   logic [RW:0]                       rem_sh;
   logic [RW+1:0]                     trial;
   logic                              q_bit;

   // restoring division, one quotient bit per cycle, dividend shifts out msb first
   assign rem_sh = {rem_ff[RW-1:0], quo_ff[RW-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign q_bit  = ~trial[RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == D_RUN) && (cnt_ff == lcmr_pkg::LAST_COUNT);
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  rem_ff   <= '0;
                  quo_ff   <= dividend;
                  dsr_ff   <= divisor;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= q_bit ? trial[RW:0] : rem_sh;
               quo_ff <= {quo_ff[RW-2:0], q_bit};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == lcmr_pkg::LAST_COUNT) begin
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign stat.busy = (state_ff != D_IDLE);
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

@@ rtl/lcmr_mul.sv @@
`default_nettype none
module lcmr_mul (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire  [lcmr_pkg::RESULT_WIDTH-1:0]     multiplicand,
   input  wire  [lcmr_pkg::RESULT_WIDTH-1:0]     multiplier,
   output lcmr_pkg::unit_stat_type               stat,
   output logic [lcmr_pkg::RESULT_WIDTH-1:0]     product,
   output logic                                  product_over
);

   localparam int RW = lcmr_pkg::RESULT_WIDTH;

   typedef enum logic {M_IDLE, M_RUN} mul_state_type;

   mul_state_type                     state_ff;
   logic                              done_ff;
   logic [RW-1:0]                     mcand_ff;
   logic [RW-1:0]                     mplier_ff;
   logic [RW+1:0]                     acc_ff;
   logic                              over_ff;
   logic [lcmr_pkg::COUNT_WIDTH-1:0]  cnt_ff;
   logic [RW+1:0]                     sum;

   // msb-first shift and add; accumulator only grows, so range overflow is sticky
   assign sum = {acc_ff[RW:0], 1'b0}
              + (mplier_ff[RW-1] ? {2'b00, mcand_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == M_RUN) && (cnt_ff == lcmr_pkg::LAST_COUNT);
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  mcand_ff  <= multiplicand;
                  mplier_ff <= multiplier;
                  acc_ff    <= '0;
                  over_ff   <= 1'b0;
                  cnt_ff    <= '0;
                  state_ff  <= M_RUN;
               end
            end
            M_RUN: begin
               mplier_ff <= {mplier_ff[RW-2:0], 1'b0};
               cnt_ff    <= cnt_ff + 1'b1;
               if (!over_ff) begin
                  acc_ff  <= sum;
                  over_ff <= |sum[RW+1:RW];
               end
               if (cnt_ff == lcmr_pkg::LAST_COUNT) begin
                  state_ff <= M_IDLE;
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign stat.busy    = (state_ff != M_IDLE);
   assign stat.done    = done_ff;
   assign product      = acc_ff[RW-1:0];
   assign product_over = over_ff;

endmodule
`default_nettype wire

@@ rtl/lcm_reduction.sv @@
`default_nettype none
// channel  | direction | signals                          | transfer when
// ---------+-----------+----------------------------------+--------------------------
// req      | in        | req_value, req_is_last           | req_valid && req_ready
// rsp      | out       | rsp_lcm_result, rsp_overflowed   | rsp_valid && rsp_ready
//
// an element that needs no arithmetic (first of a list, zero, or after the running
//   value is zero or saturated) goes from S_EVAL straight to S_FINISH
// a full fold runs through S_GCD, S_DIV and S_MUL: binary gcd (one subtract or
//   shift per cycle, then a shift back per restored factor of two), then a restoring
//   divide and a shift-add multiply, each one bit per cycle
// the last element waits in the finish step only while the result register is full
// synchronous active high reset clears the running value and flags; no clearing pass
module lcm_reduction #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  wire  signed [VALUE_WIDTH-1:0]            req_value,
   input  wire                                      req_is_last,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output logic [lcmr_pkg::RESULT_WIDTH-1:0]        rsp_lcm_result,
   output logic                                     rsp_overflowed
);

   localparam int RW        = lcmr_pkg::RESULT_WIDTH;
   // magnitude is viewed at least one bit wider than the result so range check is uniform
   localparam int MAG_WIDTH = (VALUE_WIDTH > RW) ? VALUE_WIDTH : RW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_GCD, S_DIV, S_MUL, S_FINISH
   } seq_state_type;

   seq_state_type            state_ff;

   // running fold state
   logic [RW-1:0]            running_ff;
   logic                     started_ff;
   logic                     ovf_seen_ff;

   // captured element
   logic [RW-1:0]            mag_ff;
   logic                     mag_over_ff;
   logic                     last_ff;

   // result register, frees the input side while a result waits
   logic                     rsp_valid_ff;
   logic [RW-1:0]            rsp_lcm_ff;
   logic                     rsp_ovf_ff;

   // magnitude of the incoming element
   logic [VALUE_WIDTH-1:0]   raw;
   logic [VALUE_WIDTH-1:0]   mag_raw;
   logic [MAG_WIDTH-1:0]     mag_ext;
   logic                     mag_over;
   logic [RW-1:0]            mag_sat;

   // serial units
   lcmr_pkg::unit_stat_type  gcd_stat;
   lcmr_pkg::unit_stat_type  div_stat;
   lcmr_pkg::unit_stat_type  mul_stat;
   logic [RW-1:0]            gcd_value;
   logic [RW-1:0]            quo_value;
   logic [RW-1:0]            prod_value;
   logic                     prod_over;
   logic                     gcd_start;
   logic                     div_start;
   logic                     mul_start;
   logic                     take_req;
   logic                     mag_zero;
   logic                     need_fold;
   logic                     rsp_load;

   assign raw      = req_value;
   assign mag_raw  = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
   assign mag_ext  = MAG_WIDTH'(mag_raw);
   assign mag_over = |mag_ext[MAG_WIDTH-1:RW];
   assign mag_sat  = mag_over ? lcmr_pkg::RESULT_MAX : mag_ext[RW-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign take_req  = req_valid && req_ready;

   // a saturated magnitude is never zero
   assign mag_zero  = (mag_ff == '0) && !mag_over_ff;
   // the only case that runs the arithmetic units
   assign need_fold = started_ff && !mag_zero && !ovf_seen_ff
                    && (running_ff != '0) && !mag_over_ff;

   assign gcd_start = (state_ff == S_EVAL) && need_fold;
   assign div_start = (state_ff == S_GCD) && gcd_stat.done;
   assign mul_start = (state_ff == S_DIV) && div_stat.done;

   // list result moves into the result register this cycle
   assign rsp_load  = (state_ff == S_FINISH) && last_ff && (!rsp_valid_ff || rsp_ready);

   lcmr_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start),
      .op_a    (running_ff),
      .op_b    (mag_ff),
      .stat    (gcd_stat),
      .gcd_out (gcd_value)
   );

   // running / gcd is exact, so quotient times magnitude is the new lcm
   lcmr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (running_ff),
      .divisor  (gcd_value),
      .stat     (div_stat),
      .quotient (quo_value)
   );

   lcmr_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (quo_value),
      .multiplier   (mag_ff),
      .stat         (mul_stat),
      .product      (prod_value),
      .product_over (prod_over)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         started_ff   <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (take_req) begin
                  mag_ff      <= mag_sat;
                  mag_over_ff <= mag_over;
                  last_ff     <= req_is_last;
                  state_ff    <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (!started_ff) begin
                  // first element of a list seeds the running value
                  started_ff  <= 1'b1;
                  running_ff  <= mag_ff;
                  ovf_seen_ff <= mag_over_ff;
                  state_ff    <= S_FINISH;
               end else if (mag_zero) begin
                  // zero wipes everything, saturation included
                  running_ff  <= '0;
                  ovf_seen_ff <= 1'b0;
                  state_ff    <= S_FINISH;
               end else if (ovf_seen_ff || running_ff == '0) begin
                  state_ff <= S_FINISH;
               end else if (mag_over_ff) begin
                  running_ff  <= lcmr_pkg::RESULT_MAX;
                  ovf_seen_ff <= 1'b1;
                  state_ff    <= S_FINISH;
               end else begin
                  state_ff <= S_GCD;
               end
            end
            S_GCD: begin
               if (gcd_stat.done) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (mul_stat.done) begin
                  running_ff  <= prod_over ? lcmr_pkg::RESULT_MAX : prod_value;
                  ovf_seen_ff <= prod_over;
                  state_ff    <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (rsp_load) begin
                  // hand the list result over and clear for the next list
                  rsp_valid_ff <= 1'b1;
                  rsp_lcm_ff   <= running_ff;
                  rsp_ovf_ff   <= ovf_seen_ff;
                  running_ff   <= '0;
                  started_ff   <= 1'b0;
                  ovf_seen_ff  <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lcm_result = rsp_lcm_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // at most one serial unit works at a time
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({gcd_stat.busy, div_stat.busy, mul_stat.busy}))
      else $error("more than one serial unit busy");

   // no new element is taken while any unit is still working
   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(gcd_stat.busy || div_stat.busy || mul_stat.busy))
      else $error("ready while a unit is busy");

   // saturation flag always comes with the saturated value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      ovf_seen_ff |-> (running_ff == lcmr_pkg::RESULT_MAX))
      else $error("overflow flag without saturated value");

   // a reported overflow carries the maximum
   a_rsp_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_lcm_ff == lcmr_pkg::RESULT_MAX))
      else $error("overflowed result not saturated");

   // the divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider done outside its step");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

   localparam int VALUE_WIDTH   = 32;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int IDLE_PERCENT  = 11;
   // room after the drain for any stray late transfer to show up
   localparam int DRAIN_CYCLES  = 400;
   localparam int QUIET_FIRST   = 500;
   localparam int QUIET_LAST    = 800;
   localparam int DIRECTED_ROWS = 24;

   typedef logic [lcmr_pkg::RESULT_WIDTH-1:0] lcm_type;

   // one result transfer as seen on the rsp channel
   typedef struct packed {
      lcm_type lcm;
      logic    ovf;
   } lcm_outcome_type;

   // one row of the directed table; typed rows carry their own expected result
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
      logic                          typed;
      lcm_type                       lcm;
      logic                          ovf;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                                  req_valid;
   logic                                  req_ready;
   logic signed [VALUE_WIDTH-1:0]         req_value;
   logic                                  req_is_last;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic [lcmr_pkg::RESULT_WIDTH-1:0]     rsp_lcm_result;
   logic                                  rsp_overflowed;

   // running lcm kept by the testbench, mirrors the block's list state
   lcm_type lcm_so_far;
   bit      list_open;
   bit      lcm_saturated;

   lcm_outcome_type pending_lcms[$];
   lcm_outcome_type oldest_lcm;

   int  errors = 0;
   int  cycle_count = 0;
   int  random_sent;
   // when set, neither side idles
   bit  quiet;

   // directed part: single element lists at the extremes, the overflow and zero
   // corner cases, then a few short lists checked against the running lcm
   stim_row_type directed_table [DIRECTED_ROWS] = '{
      // zero as the very first element after reset
      '{32'sh00000000, 1'b1, 1'b1, 31'h00000000, 1'b0},
      '{32'sh00000001, 1'b1, 1'b1, 31'h00000001, 1'b0},
      '{32'shFFFFFFFF, 1'b1, 1'b1, 31'h00000001, 1'b0},
      // largest magnitude that still fits
      '{32'sh7FFFFFFF, 1'b1, 1'b1, 31'h7FFFFFFF, 1'b0},
      '{32'sh80000001, 1'b1, 1'b1, 31'h7FFFFFFF, 1'b0},
      // most negative value saturates on its own
      '{32'sh80000000, 1'b1, 1'b1, 31'h7FFFFFFF, 1'b1},
      // small list, sign ignored
      '{32'sh00000004, 1'b0, 1'b0, '0, 1'b0},
      '{-32'sd6,       1'b1, 1'b0, '0, 1'b0},
      // overflow, then a nonzero element leaves it saturated
      '{32'sh00010000, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh00010001, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh00000003, 1'b1, 1'b0, '0, 1'b0},
      // zero after overflow clears the flag
      '{32'sh80000000, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh00000000, 1'b1, 1'b1, 31'h00000000, 1'b0},
      // running value stuck at zero
      '{32'sh00000000, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh00000007, 1'b1, 1'b1, 31'h00000000, 1'b0},
      '{32'sh0000000C, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh00000012, 1'b0, 1'b0, '0, 1'b0},
      '{-32'sd30,      1'b1, 1'b0, '0, 1'b0},
      // shared factor keeps the product in range
      '{32'sh7FFFFFFE, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh00000002, 1'b1, 1'b0, '0, 1'b0},
      // coprime pair just below the limit
      '{32'sh0000B505, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh0000B504, 1'b1, 1'b0, '0, 1'b0},
      '{32'sh80000001, 1'b0, 1'b0, '0, 1'b0},
      '{32'sh80000000, 1'b1, 1'b0, '0, 1'b0}
   };

   lcm_reduction #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_lcm_result(rsp_lcm_result),
      .rsp_overflowed(rsp_overflowed)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_lcms.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned exp);
      $display("cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, exp);
      errors++;
   endtask

   function automatic longint unsigned gcd_of(input longint unsigned a,
                                              input longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // fold one accepted element into the running lcm; on the last element hand
   // back the list's result and clear for the next list
   task automatic lcm_fold(input logic signed [VALUE_WIDTH-1:0] value, input logic last,
                           output bit produced, output lcm_outcome_type outcome);
      longint unsigned mag;
      longint unsigned g;
      longint unsigned prod;
      mag = (value < 0) ? -longint'(value) : longint'(value);
      produced = 1'b0;
      outcome  = '0;
      if (!list_open) begin
         list_open = 1'b1;
         if (mag > lcmr_pkg::RESULT_MAX) begin
            lcm_so_far    = lcmr_pkg::RESULT_MAX;
            lcm_saturated = 1'b1;
         end else begin
            lcm_so_far = lcm_type'(mag);
         end
      end else if (mag == 0) begin
         // true lcm is exactly zero, even after saturation
         lcm_so_far    = '0;
         lcm_saturated = 1'b0;
      end else if (!lcm_saturated && lcm_so_far != 0) begin
         if (mag > lcmr_pkg::RESULT_MAX) begin
            lcm_so_far    = lcmr_pkg::RESULT_MAX;
            lcm_saturated = 1'b1;
         end else begin
            g    = gcd_of(lcm_so_far, mag);
            prod = (longint'(lcm_so_far) / g) * mag;
            if (prod > lcmr_pkg::RESULT_MAX) begin
               lcm_so_far    = lcmr_pkg::RESULT_MAX;
               lcm_saturated = 1'b1;
            end else begin
               lcm_so_far = lcm_type'(prod);
            end
         end
      end
      if (last) begin
         produced      = 1'b1;
         outcome.lcm   = lcm_so_far;
         outcome.ovf   = lcm_saturated;
         lcm_so_far    = '0;
         list_open     = 1'b0;
         lcm_saturated = 1'b0;
      end
   endtask

   // random element: mostly small numbers and products of small primes so that
   // lists fold for a while before they saturate, plus full-range noise
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      int unsigned mag;
      int unsigned kind;
      int unsigned primes [6] = '{2, 3, 5, 7, 11, 13};
      kind = $urandom_range(99);
      if (kind < 40) begin
         mag = $urandom_range(64, 1);
      end else if (kind < 62) begin
         mag = 1;
         repeat ($urandom_range(5, 1)) mag = mag * primes[$urandom_range(5)];
      end else if (kind < 66) begin
         return '0;
      end else if (kind < 86) begin
         return $urandom();
      end else if (kind < 92) begin
         case ($urandom_range(3))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000001;
            default: return 32'sh7FFFFFFE;
         endcase
      end else begin
         mag = 32'd1 << $urandom_range(30);
      end
      return $urandom_range(1) ? -$signed(mag) : $signed(mag);
   endfunction

   // present one element, hold it until the transfer, then predict
   task automatic send_element(input stim_row_type row);
      bit              produced;
      lcm_outcome_type outcome;
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= row.value;
      req_is_last <= row.last;
      do @(posedge clock); while (!req_ready);
      lcm_fold(row.value, row.last, produced, outcome);
      if (produced)
         pending_lcms.push_back(row.typed ? lcm_outcome_type'({row.lcm, row.ovf}) : outcome);
   endtask

   // result side backpressure
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // compare each result transfer with the oldest expected lcm
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lcms.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_lcm_result, 0);
         end else begin
            oldest_lcm = pending_lcms.pop_front();
            if (rsp_lcm_result !== oldest_lcm.lcm)
               report_mismatch("lcm_result", rsp_lcm_result, oldest_lcm.lcm);
            if (rsp_overflowed !== oldest_lcm.ovf)
               report_mismatch("overflowed", rsp_overflowed, oldest_lcm.ovf);
         end
      end
   end

   initial begin
      stim_row_type row;
      int           list_len;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = '0;
      req_is_last   = 1'b0;
      rsp_ready     = 1'b0;
      quiet         = 1'b0;
      random_sent   = 0;
      lcm_so_far    = '0;
      list_open     = 1'b0;
      lcm_saturated = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[i]) send_element(directed_table[i]);

      // random lists: mostly short, now and then a long one
      while (random_sent < RANDOM_ITEMS) begin
         list_len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
         for (int k = 0; k < list_len; k++) begin
            quiet     = (random_sent >= QUIET_FIRST) && (random_sent < QUIET_LAST);
            row       = '0;
            row.value = pick_value();
            row.last  = (k == list_len - 1);
            send_element(row);
            random_sent++;
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // drain, then give any stray transfer time to show up
      while (pending_lcms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
